// ===== rtl/core/b64d_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the Base64 stream decoder
// Character codes, error codes, the sextet map and the command record that
// travels from the front end to the back end.
// ---------------------------------------------------------------------------
package b64d_pkg;

  // ASCII codes of interest
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_DIG_0 = 8'h30;
  localparam logic [7:0] CHAR_DIG_9 = 8'h39;

  // Sextet values
  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;

  // Group position that completes a group, flush position and bad length
  localparam logic [1:0] POS_THREE = 2'd3;
  localparam logic [1:0] POS_TWO   = 2'd2;
  localparam logic [1:0] LEN_ONE   = 2'd1;

  // Final result error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CHAR = 2'd1;
  localparam logic [1:0] ERR_LEN  = 2'd2;

  // Beat counts of a command
  localparam logic [1:0] BEATS_ONE   = 2'd1;
  localparam logic [1:0] BEATS_TWO   = 2'd2;
  localparam logic [1:0] BEATS_THREE = 2'd3;

  // Sextet lookup result
  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // One command: up to three beats, bytes packed first-out highest
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  nbeats;
    logic        bvalid;
    logic        end_flag;
    logic [1:0]  err;
  } b64d_cmd_t;

  // Queue status toward the top level
  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  // Map one character to its sextet
  function automatic sextet_t map_char(input logic [7:0] c);
    sextet_t s;
    s.ok    = 1'b1;
    s.value = '0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      s.value = 6'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      s.value = SEXTET_LOWER_BASE + 6'(c - CHAR_LO_A);
    end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
      s.value = SEXTET_DIGIT_BASE + 6'(c - CHAR_DIG_0);
    end else if (c == CHAR_PLUS) begin
      s.value = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      s.value = SEXTET_SLASH;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b64d_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_if: stream channels of the Base64 decoder
// Character channel in, decoded byte channel out, valid/ready handshake.
// ---------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_mark;
  logic [1:0] error_code;

  modport source (output valid, out_byte, byte_valid, end_mark, error_code, input ready);
  modport sink   (input valid, out_byte, byte_valid, end_mark, error_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_front: character intake and classification
// Maps each character, keeps the open group and message state, and pushes a
// command whenever a character completes a group or ends the message.
// ---------------------------------------------------------------------------
module b64d_front (
  input  wire                 clk,
  input  wire                 rst_n,
  b64d_char_if.sink           in_chan,
  input  wire                 q_ready,
  output logic                q_push,
  output b64d_pkg::b64d_cmd_t q_cmd
);
  import b64d_pkg::*;

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  len_r, len_nxt;
  logic        pad_r, pad_nxt;
  logic [1:0]  err_r, err_nxt;

  sextet_t     sx;
  logic [23:0] full;
  logic        group_done;
  logic        beat_in;
  logic [1:0]  final_err;

  assign in_chan.ready = q_ready;
  assign beat_in       = in_chan.valid && q_ready;

  // Classify the character and update the open group
  always_comb begin
    sx         = map_char(in_chan.char_code);
    full       = {acc_r, sx.value};
    acc_nxt    = acc_r;
    pos_nxt    = pos_r;
    pad_nxt    = pad_r;
    err_nxt    = err_r;
    len_nxt    = len_r + 2'd1;
    group_done = 1'b0;
    if (!pad_r) begin
      if (in_chan.char_code == CHAR_PAD) begin
        pad_nxt = 1'b1;
      end else if (err_r == ERR_NONE) begin
        if (!sx.ok) begin
          err_nxt = ERR_CHAR;
        end else if (pos_r == POS_THREE) begin
          group_done = 1'b1;
          acc_nxt    = '0;
          pos_nxt    = '0;
        end else begin
          acc_nxt = full[17:0];
          pos_nxt = pos_r + 2'd1;
        end
      end
    end
    final_err = (len_nxt == LEN_ONE) ? ERR_LEN : err_nxt;
  end

  // Build the command for this beat
  always_comb begin
    q_cmd          = '0;
    q_cmd.nbeats   = BEATS_THREE;
    q_cmd.bvalid   = 1'b1;
    q_cmd.data     = full;
    q_push         = beat_in && (group_done || in_chan.last_char);
    if (in_chan.last_char) begin
      q_cmd.end_flag = 1'b1;
      if (final_err != ERR_NONE) begin
        q_cmd.data   = '0;
        q_cmd.nbeats = BEATS_ONE;
        q_cmd.bvalid = 1'b0;
        q_cmd.err    = final_err;
      end else if (!group_done) begin
        if (pos_nxt == POS_THREE) begin
          q_cmd.data   = {acc_nxt[17:2], 8'h00};
          q_cmd.nbeats = BEATS_TWO;
        end else if (pos_nxt == POS_TWO) begin
          q_cmd.data   = {acc_nxt[11:4], 16'h0000};
          q_cmd.nbeats = BEATS_ONE;
        end else begin
          q_cmd.data   = '0;
          q_cmd.nbeats = BEATS_ONE;
          q_cmd.bvalid = 1'b0;
        end
      end
    end
  end

  // Advance message state; clear it after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
      len_r <= '0;
      pad_r <= 1'b0;
      err_r <= ERR_NONE;
    end else if (beat_in) begin
      if (in_chan.last_char) begin
        acc_r <= '0;
        pos_r <= '0;
        len_r <= '0;
        pad_r <= 1'b0;
        err_r <= ERR_NONE;
      end else begin
        acc_r <= acc_nxt;
        pos_r <= pos_nxt;
        len_r <= len_nxt;
        pad_r <= pad_nxt;
        err_r <= err_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_queue: command queue between front end and back end
// Small register FIFO; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  b64d_pkg::b64d_cmd_t   push_cmd,
  output logic                  push_ready,
  input  wire                   pop,
  output b64d_pkg::b64d_cmd_t   pop_cmd,
  output logic                  pop_valid,
  output b64d_pkg::b64d_qstat_t stat
);
  import b64d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_cmd_t        entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign stat.full  = !push_ready;
  assign stat.empty = !pop_valid;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Wrap pointers, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64d_back: command execution and result output
// Takes one command, sends its beats through an output register one per cycle
// while ready is high, and fetches the next command as the last beat leaves.
// ---------------------------------------------------------------------------
module b64d_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  b64d_pkg::b64d_cmd_t q_cmd,
  input  wire                 q_valid,
  output logic                q_pop,
  b64d_byte_if.source         out_chan
);
  import b64d_pkg::*;

  b64d_cmd_t  cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r;
  logic       end_r, end_nxt;
  logic [1:0] err_r, err_nxt;
  logic       adv, last_beat;

  assign adv       = cur_valid_r && (!out_valid_r || out_chan.ready);
  assign last_beat = (idx_r == cur_r.nbeats - 2'd1);
  assign q_pop     = q_valid && (!cur_valid_r || (adv && last_beat));

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_byte   = byte_r;
  assign out_chan.byte_valid = bvalid_r;
  assign out_chan.end_mark   = end_r;
  assign out_chan.error_code = err_r;

  // Select the beat at the current index
  always_comb begin
    case (idx_r)
      2'd0:    byte_nxt = cur_r.data[23:16];
      2'd1:    byte_nxt = cur_r.data[15:8];
      default: byte_nxt = cur_r.data[7:0];
    endcase
    end_nxt = cur_r.end_flag && last_beat;
    err_nxt = end_nxt ? cur_r.err : ERR_NONE;
    idx_nxt = last_beat ? 2'd0 : idx_r + 2'd1;
  end

  // Hold the working command and beat index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        idx_r <= idx_nxt;
      end
      if (q_pop) begin
        cur_valid_r <= 1'b1;
      end else if (adv && last_beat) begin
        cur_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (adv) begin
      byte_r   <= byte_nxt;
      bvalid_r <= cur_r.bvalid;
      end_r    <= end_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/base64_stream_decoder_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// base64_stream_decoder_top: streaming Base64 decoder
// Front end decodes characters into commands, a short queue decouples it
// from the back end, which sends up to three result beats per command.
//
//   channel   direction  payload
//   in_chan   sink       char_code[7:0], last_char
//   out_chan  source     out_byte[7:0], byte_valid, end_mark, error_code[1:0]
//
// One character per cycle while the queue has room; a full group of four
// characters yields three beats, so the input side sets the sustained rate.
// Results pass the queue, the command register and the output register.
// Synchronous active-low reset clears message state, queue and output.
// Either side may stall; the queue absorbs up to QUEUE_DEPTH commands.
// ---------------------------------------------------------------------------
module base64_stream_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire          clk,
  input  wire          rst_n,
  b64d_char_if.sink    in_chan,
  b64d_byte_if.source  out_chan
);
  import b64d_pkg::*;

  b64d_cmd_t   push_cmd, pop_cmd;
  logic        push, push_ready, pop, pop_valid;
  b64d_qstat_t q_stat;

  b64d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_ready (push_ready),
    .q_push  (push),
    .q_cmd   (push_cmd)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .stat       (q_stat)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_cmd    (pop_cmd),
    .q_valid  (pop_valid),
    .q_pop    (pop),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  // An error report is a lone end beat without data
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_cmd.err != ERR_NONE |->
      push_cmd.end_flag && !push_cmd.bvalid && push_cmd.nbeats == BEATS_ONE)
    else $error("error command malformed");

  // A push without a pop leaves the queue non-empty
  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_ready && !pop |=> !q_stat.empty)
    else $error("queue lost a command");

  // Never pop from an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Output error code appears only on an end beat
  a_out_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.error_code != ERR_NONE |->
      out_chan.end_mark && !out_chan.byte_valid)
    else $error("error code on non-final beat");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: Base64 stream decoder check
// Drives encoded messages one character per beat, predicts every decoded
// byte beat from its own decoder state and compares each beat that leaves
// the block, field by field, with the oldest prediction. Both channels idle
// and stall at random; one long receiver hold-off and one drain pause apply
// pressure to the internal queue.
// ---------------------------------------------------------------------------
module testbench;
  import b64d_pkg::*;

  localparam int          LIMIT_CYCLES  = 200000;
  localparam int          RANDOM_CHARS  = 200;
  localparam int          QUIET_TAIL    = 40;
  localparam int          LONG_HOLD     = 100;
  localparam int          HOLD_TRIGGER  = 60;
  localparam int          SETTLE_CYCLES = 20;
  localparam logic [6:0]  SEXTET_NONE   = 7'd64;

  // One pending character beat
  typedef struct {
    logic [7:0] code;
    logic       is_last;
    bit         drain;
  } char_beat_t;

  // One decoded result beat
  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       endm;
    logic [1:0] code;
  } dec_beat_t;

  logic clk;
  logic rst_n;

  b64d_char_if char_ch ();
  b64d_byte_if byte_ch ();

  base64_stream_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (char_ch),
    .out_chan (byte_ch)
  );

  string      alphabet;
  logic [6:0] sextet_lut [0:255];

  char_beat_t pending_chars [$];
  dec_beat_t  expected_beats [$];

  // Decoder state of the prediction
  logic [17:0] acc_bits;
  logic [1:0]  sextets_held;
  logic [1:0]  chars_mod4;
  logic        pad_hit;
  logic [1:0]  sticky_err;

  bit char_taken;
  int chars_accepted;
  int beats_checked;
  int messages_done;
  int messages_errored;
  int mismatches;
  int random_chars;
  int cycle_count;
  int send_gap;
  int stall_left;
  int hold_left;
  bit long_hold_done;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Predict the beats caused by one accepted character
  task automatic decode_char(input logic [7:0] c, input logic is_last);
    logic [6:0]  sx;
    logic [23:0] full;
    logic [7:0]  b [3];
    int          nb;
    logic [1:0]  e;
    nb = 0;
    chars_mod4 = chars_mod4 + 2'd1;
    if (!pad_hit) begin
      if (c == CHAR_PAD) begin
        pad_hit = 1'b1;
      end else if (sticky_err == ERR_NONE) begin
        sx = sextet_lut[c];
        if (sx == SEXTET_NONE) begin
          sticky_err = ERR_CHAR;
        end else if (sextets_held == POS_THREE) begin
          full = {acc_bits, sx[5:0]};
          b[0] = full[23:16];
          b[1] = full[15:8];
          b[2] = full[7:0];
          nb = 3;
          acc_bits = '0;
          sextets_held = '0;
        end else begin
          acc_bits = {acc_bits[11:0], sx[5:0]};
          sextets_held = sextets_held + 2'd1;
        end
      end
    end
    if (!is_last) begin
      for (int i = 0; i < nb; i++) expected_beats.push_back('{b[i], 1'b1, 1'b0, ERR_NONE});
    end else begin
      e = (chars_mod4 == LEN_ONE) ? ERR_LEN : sticky_err;
      if (e != ERR_NONE) begin
        expected_beats.push_back('{8'h00, 1'b0, 1'b1, e});
        messages_errored++;
      end else begin
        // Flush an open group of three or two sextets
        if (nb == 0 && sextets_held == POS_THREE) begin
          b[0] = acc_bits[17:10];
          b[1] = acc_bits[9:2];
          nb = 2;
        end else if (nb == 0 && sextets_held == POS_TWO) begin
          b[0] = acc_bits[11:4];
          nb = 1;
        end
        if (nb == 0) begin
          expected_beats.push_back('{8'h00, 1'b0, 1'b1, ERR_NONE});
        end else begin
          for (int i = 0; i < nb; i++) begin
            expected_beats.push_back('{b[i], 1'b1, (i == nb - 1), ERR_NONE});
          end
        end
      end
      messages_done++;
      acc_bits = '0;
      sextets_held = '0;
      chars_mod4 = '0;
      pad_hit = 1'b0;
      sticky_err = ERR_NONE;
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Queue one message, last mark on its final character
  task automatic push_message(input logic [7:0] msg [$], input bit drain_first);
    for (int i = 0; i < msg.size(); i++) begin
      pending_chars.push_back('{msg[i], (i == msg.size() - 1), drain_first && (i == 0)});
    end
  endtask

  task automatic push_text(input string s, input bit drain_first);
    logic [7:0] msg [$];
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    push_message(msg, drain_first);
  endtask

  // Mostly well-formed text with random content, some corrupted or noise
  task automatic push_random_message(input bit drain_first);
    logic [7:0] msg [$];
    int         kind;
    int         groups;
    int         tail;
    int         idx;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      groups = $urandom_range(0, 3);
      tail = $urandom_range(0, 4);
      if (groups == 0 && tail == 0) groups = 1;
      repeat (groups * 4) msg.push_back(alphabet[$urandom_range(0, 63)]);
      repeat ((tail == 2 || tail == 4) ? 3 : (tail == 0 ? 0 : 2)) begin
        msg.push_back(alphabet[$urandom_range(0, 63)]);
      end
      if (tail == 1) begin
        msg.push_back(CHAR_PAD);
        msg.push_back(CHAR_PAD);
      end else if (tail == 2) begin
        msg.push_back(CHAR_PAD);
      end
      if (kind == 7) begin
        idx = $urandom_range(0, msg.size() - 1);
        msg[idx] = 8'($urandom_range(0, 255));
      end
    end else begin
      repeat ($urandom_range(1, 9)) begin
        case ($urandom_range(0, 2))
          0: msg.push_back(8'($urandom_range(0, 255)));
          1: msg.push_back(CHAR_PAD);
          default: msg.push_back(alphabet[$urandom_range(0, 63)]);
        endcase
      end
    end
    random_chars += msg.size();
    push_message(msg, drain_first);
  endtask

  // Sample both channels, predict on character beats, check result beats
  always @(posedge clk) begin
    dec_beat_t got;
    dec_beat_t want;
    char_taken = 1'b0;
    if (rst_n) begin
      if (char_ch.valid && char_ch.ready) begin
        char_taken = 1'b1;
        chars_accepted++;
        decode_char(char_ch.char_code, char_ch.last_char);
      end
      if (byte_ch.valid && byte_ch.ready) begin
        got = '{byte_ch.out_byte, byte_ch.byte_valid, byte_ch.end_mark, byte_ch.error_code};
        if (expected_beats.size() == 0) begin
          $display("%0t ns: unexpected beat, expected none, got byte %0h bv %0b end %0b err %0d",
                   $time, got.data, got.bvalid, got.endm, got.code);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("out_byte", want.data, got.data);
          check_field("byte_valid", 8'(want.bvalid), 8'(got.bvalid));
          check_field("end_mark", 8'(want.endm), 8'(got.endm));
          check_field("error_code", 8'(want.code), 8'(got.code));
          beats_checked++;
        end
      end
    end
  end

  // Drive character beats, idle in bursts, hold for a drain pause
  always @(negedge clk) begin
    char_beat_t item;
    logic       nv;
    bit         quiet;
    quiet = (pending_chars.size() < QUIET_TAIL);
    if (rst_n && (!char_ch.valid || char_taken)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_chars.size() == 0) begin
        nv = 1'b0;
      end else if (pending_chars[0].drain && expected_beats.size() != 0) begin
        nv = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(1, 14) - 1;
      end else begin
        item = pending_chars.pop_front();
        char_ch.char_code <= item.code;
        char_ch.last_char <= item.is_last;
        nv = 1'b1;
      end
      char_ch.valid <= nv;
    end
  end

  // Drive ready: random stall bursts and one long hold-off
  always @(negedge clk) begin
    logic nr;
    bit   quiet;
    quiet = (pending_chars.size() < QUIET_TAIL);
    nr = 1'b1;
    if (!rst_n) begin
      nr = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (!long_hold_done && chars_accepted >= HOLD_TRIGGER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      nr = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nr = 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      nr = 1'b0;
    end
    byte_ch.ready <= nr;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_beats.size());
      $display("FAIL base64_stream_decoder_top");
      $finish;
    end
  end

  initial begin
    logic [7:0] msg [$];
    rst_n = 1'b0;
    char_ch.valid = 1'b0;
    char_ch.char_code = '0;
    char_ch.last_char = 1'b0;
    byte_ch.ready = 1'b0;
    acc_bits = '0;
    sextets_held = '0;
    chars_mod4 = '0;
    pad_hit = 1'b0;
    sticky_err = ERR_NONE;
    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    for (int i = 0; i < 256; i++) sextet_lut[i] = SEXTET_NONE;
    for (int i = 0; i < 64; i++) sextet_lut[alphabet[i]] = 7'(i);

    // Directed: padded tails, alphabet edges, bad characters, short length,
    // junk after padding with a lone sextet dropped at the end
    push_text("TWE=", 1'b0);
    push_text("TQ==", 1'b0);
    push_text("AZaz09+/", 1'b0);
    msg = '{8'h41, 8'h00, 8'h42, 8'h2A};
    push_message(msg, 1'b0);
    msg = '{8'h2A};
    push_message(msg, 1'b0);
    msg = '{8'h51, CHAR_PAD, 8'hFF, 8'h7E};
    push_message(msg, 1'b0);

    // Random part; the first message waits for the pipe to drain
    push_random_message(1'b1);
    while (random_chars < RANDOM_CHARS) push_random_message(1'b0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    while (pending_chars.size() != 0 || char_ch.valid || expected_beats.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("decoded %0d messages from %0d characters, %0d beats checked",
             messages_done, chars_accepted, beats_checked);
    $display("%0d messages ended in error, %0d mismatches", messages_errored, mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASS base64_stream_decoder_top");
    end else begin
      $display("FAIL base64_stream_decoder_top");
    end
    $finish;
  end

endmodule
